// ----- design/dpf_pkg.sv -----
package dpf_pkg;

  localparam int ID_ENTRIES_DEF = 128;
  localparam int ID_W           = 32;
  localparam int TYPE_W         = 8;
  localparam int LEN_W          = 11;

  localparam logic [LEN_W-1:0]  HEADER_BYTES = 11'd5;
  localparam logic [TYPE_W-1:0] PAYLOAD_TYPE = 8'h50;

  typedef enum logic [2:0] {
    V_SHORT         = 3'd0,
    V_DUPLICATE     = 3'd1,
    V_RETRY_DROPPED = 3'd2,
    V_NEW           = 3'd3,
    V_PAYLOAD_RETRY = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ----- design/dpf_if.sv -----
interface dpf_in_if import dpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   packet_id;
  logic [TYPE_W-1:0] msg_type;
  logic [LEN_W-1:0]  packet_length;

  modport source (output valid, packet_id, msg_type, packet_length, input ready);
  modport sink   (input valid, packet_id, msg_type, packet_length, output ready);
endinterface

interface dpf_out_if import dpf_pkg::*; ();
  logic              valid;
  logic              ready;
  verdict_t          verdict;
  logic [TYPE_W-1:0] type_out;

  modport source (output valid, verdict, type_out, input ready);
  modport sink   (input valid, verdict, type_out, output ready);
endinterface

// ----- design/dpf_id_store.sv -----
module dpf_id_store import dpf_pkg::*; #(
  parameter int ID_ENTRIES = ID_ENTRIES_DEF,
  localparam int AW = (ID_ENTRIES > 1) ? $clog2(ID_ENTRIES) : 1,
  localparam int CW = $clog2(ID_ENTRIES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [ID_W-1:0] rd_data,
  input  logic            wr_en,
  input  logic [ID_W-1:0] wr_data
);

  logic [ID_W-1:0] mem [ID_ENTRIES];
  logic [ID_W-1:0] rd_data_r;
  logic            rd_live_r;
  logic [AW-1:0]   wp_r;
  logic [CW-1:0]   fill_r;

  // entries are written strictly in pointer order, so the fill count marks
  // which ones have not been written yet and so read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      fill_r    <= '0;
      rd_live_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_live_r <= (CW'(rd_addr) < fill_r);
      end
      if (wr_en) begin
        wp_r <= (wp_r == AW'(ID_ENTRIES - 1)) ? '0 : wp_r + 1'b1;
        if (fill_r != CW'(ID_ENTRIES)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  assign rd_data = rd_live_r ? rd_data_r : '0;

endmodule

// ----- design/duplicate_packet_id_filter.sv -----
// Flow: a short request goes straight to the done state; otherwise the
// store is walked one entry per cycle through its single read port, and the
// scan stops at the first entry whose upper ID bits match, or after the last entry.
// One request at a time: the next is taken only once the done state has moved the
// result into the output register, which waits while the previous result is held.
// Reset (synchronous, rst_n low): control cleared, store reads as all zero.
module duplicate_packet_id_filter import dpf_pkg::*; #(
  parameter int ID_ENTRIES = ID_ENTRIES_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  dpf_in_if.sink   in_chan,
  dpf_out_if.source out_chan
);

  localparam int AW = (ID_ENTRIES > 1) ? $clog2(ID_ENTRIES) : 1;
  localparam int CW = $clog2(ID_ENTRIES + 1);

  state_t            state_r, state_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  verdict_t          verdict_r, verdict_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  verdict_t          out_verdict_r, out_verdict_nxt;
  logic [TYPE_W-1:0] out_type_r, out_type_nxt;

  logic            rd_en;
  logic [ID_W-1:0] rd_data;
  logic            wr_en;
  logic            in_acc;
  logic            match_hi;
  logic            scan_end;

  dpf_id_store #(.ID_ENTRIES(ID_ENTRIES)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_data (id_r)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.verdict  = out_verdict_r;
  assign out_chan.type_out = out_type_r;

  assign match_hi = cmp_vld_r && (rd_data[ID_W-1:8] == id_r[ID_W-1:8]);
  assign scan_end = cmp_vld_r && (cmp_idx_r == AW'(ID_ENTRIES - 1));

  always_comb begin
    state_nxt       = state_r;
    id_nxt          = id_r;
    type_nxt        = type_r;
    verdict_nxt     = verdict_r;
    idx_nxt         = idx_r;
    cmp_idx_nxt     = cmp_idx_r;
    cmp_vld_nxt     = 1'b0;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_verdict_nxt = out_verdict_r;
    out_type_nxt    = out_type_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          id_nxt   = in_chan.packet_id;
          type_nxt = in_chan.msg_type;
          idx_nxt  = '0;
          if (in_chan.packet_length <= HEADER_BYTES) begin
            verdict_nxt = V_SHORT;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while the previous entry is compared
        if (idx_r < CW'(ID_ENTRIES)) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + 1'b1;
        end
        if (match_hi) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_DONE;
          if (rd_data[7:0] == id_r[7:0]) begin
            verdict_nxt = V_DUPLICATE;
          end else begin
            wr_en       = 1'b1;
            verdict_nxt = (type_r == PAYLOAD_TYPE) ? V_PAYLOAD_RETRY : V_RETRY_DROPPED;
          end
        end else if (scan_end) begin
          cmp_vld_nxt = 1'b0;
          wr_en       = 1'b1;
          verdict_nxt = V_NEW;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
          out_type_nxt    = type_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r          <= id_nxt;
    type_r        <= type_nxt;
    verdict_r     <= verdict_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_type_r    <= out_type_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("request accepted but controller stayed idle");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= CW'(ID_ENTRIES)))
    else $error("scan index ran past the store");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside the done state");

  a_dup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_SCAN) |=> (verdict_r != V_DUPLICATE))
    else $error("store written for an exact duplicate");

endmodule
